/* rtl/baro_sensor_compensation_assert.svh */
// ----------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// Same-cycle implication.
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_T1_T2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_T3_P1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_P2_P3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_P4_P5 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_P6_P7 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_P8_P9 = 3'd5;

  localparam logic signed [23:0] TEMP_OFS   = 24'sd128000;
  localparam logic [20:0]        PRESS_FULL = 21'd1048576;
  localparam logic [11:0]        DIV_SCALE  = 12'd3125;
  localparam logic signed [63:0] V1_BIAS    = 64'sh0000_8000_0000_0000;

  localparam int unsigned DIV_STG = 64;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } req_in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_q24_8;
    logic               press_invalid;
  } res_out_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } trim_t;

  // Values that ride along the divider stages.
  typedef struct packed {
    logic signed [31:0] temp;
    logic               dz;
    logic               neg;
    logic [30:0]        ud;
  } div_side_t;

  typedef struct packed {
    div_side_t   side;
    logic [63:0] un;
  } div_req_t;

  typedef struct packed {
    div_side_t   side;
    logic [63:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

/* rtl/baro_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer trim compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// Usage:
//   Load the six trim registers through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   the pipeline is empty; indexes above five are ignored.
//   A request (raw temperature + raw pressure) enters on in_valid_i when
//   in_stall_o is low; one result leaves on out_valid_o when out_stall_i is
//   low. Results keep request order.
//   Stages: 11 front stages, 64 divider stages of one quotient bit each, and
//   7 back stages.
//   Throughput: one request per cycle when not stalled; the 64-stage divider
//   is fully pipelined, so every unit takes a new request each cycle.
//   Stall: the output register is the last stage. When it holds a result
//   and out_stall_i is high, the whole pipeline freezes and in_stall_o goes
//   high in the same cycle; nothing is dropped or repeated.
//   Reset: all valid bits and the trim registers clear to zero.
//   A zero divisor gives pressure 0 with press_invalid set; temperature is
//   still correct.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bsc_pkg::req_in_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bsc_pkg::res_out_t               out_res_o,
  input  logic                            cfg_we_i,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                     cfg_wdata_i
);
  import bsc_pkg::*;

  // trim register file
  logic [31:0] trim_t1_t2_q, trim_t3_p1_q, trim_p2_p3_q;
  logic [31:0] trim_p4_p5_q, trim_p6_p7_q, trim_p8_p9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_t1_t2_q <= '0;
      trim_t3_p1_q <= '0;
      trim_p2_p3_q <= '0;
      trim_p4_p5_q <= '0;
      trim_p6_p7_q <= '0;
      trim_p8_p9_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRIM_T1_T2: trim_t1_t2_q <= cfg_wdata_i;
        CFG_TRIM_T3_P1: trim_t3_p1_q <= cfg_wdata_i;
        CFG_TRIM_P2_P3: trim_p2_p3_q <= cfg_wdata_i;
        CFG_TRIM_P4_P5: trim_p4_p5_q <= cfg_wdata_i;
        CFG_TRIM_P6_P7: trim_p6_p7_q <= cfg_wdata_i;
        CFG_TRIM_P8_P9: trim_p8_p9_q <= cfg_wdata_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  trim_t trim;

  always_comb begin
    trim.t1 = trim_t1_t2_q[15:0];
    trim.t2 = trim_t1_t2_q[31:16];
    trim.t3 = trim_t3_p1_q[15:0];
    trim.p1 = trim_t3_p1_q[31:16];
    trim.p2 = trim_p2_p3_q[15:0];
    trim.p3 = trim_p2_p3_q[31:16];
    trim.p4 = trim_p4_p5_q[15:0];
    trim.p5 = trim_p4_p5_q[31:16];
    trim.p6 = trim_p6_p7_q[15:0];
    trim.p7 = trim_p6_p7_q[31:16];
    trim.p8 = trim_p8_p9_q[15:0];
    trim.p9 = trim_p8_p9_q[31:16];
  end

  // Global advance: the pipeline moves unless a finished result is held by out_stall_i.
  logic pipe_en;
  assign pipe_en    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !pipe_en;

  logic     front_vld, div_vld;
  div_req_t front_req;
  div_res_t div_res;

  bsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .trim_i      (trim),
    .out_valid_o (front_vld),
    .out_req_o   (front_req)
  );

  bsc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (front_vld),
    .in_req_i    (front_req),
    .out_valid_o (div_vld),
    .out_res_o   (div_res)
  );

  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (div_vld),
    .in_res_i    (div_res),
    .trim_i      (trim),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

`include "baro_sensor_compensation_assert.svh"

  `BSC_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_o && out_res_o.press_invalid, out_res_o.press_q24_8 == '0, "invalid pressure result is not zero")

endmodule

`default_nettype wire

/* rtl/bsc_front.sv */
// ----------------------------------------------------------------------------
// bsc_front
// Temperature compensation and pressure terms up to the divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  bsc_pkg::req_in_t   in_req_i,
  input  bsc_pkg::trim_t     trim_i,
  output logic               out_valid_o,
  output bsc_pkg::div_req_t  out_req_o
);
  import bsc_pkg::*;

  localparam int unsigned NSTG = 11;

  logic [NSTG-1:0] vld_q;

  logic [19:0]        rp_q  [7];  // raw pressure, S1..S7
  logic signed [31:0] tmp_q [7];  // temperature result, S4..S10

  // S1: trim differences and first products
  logic signed [17:0] s1_a;
  logic signed [16:0] s1_b;
  logic signed [33:0] s1_pa_d, s1_pa_q, s1_bb_d, s1_bb_q;

  assign s1_a = $signed({1'b0, in_req_i.raw_temp[19:3]}) - $signed({1'b0, trim_i.t1, 1'b0});
  assign s1_b = $signed({1'b0, in_req_i.raw_temp[19:4]}) - $signed({1'b0, trim_i.t1});
  assign s1_pa_d = s1_a * $signed(trim_i.t2);
  assign s1_bb_d = s1_b * s1_b;

  // S2
  logic signed [31:0] s2_pa32, s2_bb32, s2_v1t_w, s2_bbs_w;
  logic signed [19:0] s2_bbs;
  logic signed [35:0] s2_m_d, s2_m_q;
  logic signed [20:0] s2_v1t_q;

  assign s2_pa32  = s1_pa_q[31:0];
  assign s2_bb32  = s1_bb_q[31:0];
  assign s2_v1t_w = s2_pa32 >>> 11;
  assign s2_bbs_w = s2_bb32 >>> 12;
  assign s2_bbs   = s2_bbs_w[19:0];
  assign s2_m_d   = s2_bbs * $signed(trim_i.t3);

  // S3: fine temperature
  logic signed [31:0] s3_m32, s3_v2t_w;
  logic signed [17:0] s3_v2t;
  logic signed [21:0] s3_tf_d, s3_tf_q;

  assign s3_m32   = s2_m_q[31:0];
  assign s3_v2t_w = s3_m32 >>> 14;
  assign s3_v2t   = s3_v2t_w[17:0];
  assign s3_tf_d  = 22'(s2_v1t_q) + 22'(s3_v2t);

  // S4: centidegrees and pressure offset
  logic signed [25:0] s4_t5;
  logic signed [31:0] s4_temp_d;
  logic signed [23:0] s4_x_d, s4_x_q;

  assign s4_t5     = 26'(s3_tf_q) * 26'sd5 + 26'sd128;
  assign s4_temp_d = 32'(s4_t5 >>> 8);
  assign s4_x_d    = 24'(s3_tf_q) - TEMP_OFS;

  // S5
  logic signed [47:0] s5_xx_d, s5_xx_q;
  logic signed [39:0] s5_xp5_d, s5_xp5_q, s5_xp2_d, s5_xp2_q;

  assign s5_xx_d  = s4_x_q * s4_x_q;
  assign s5_xp5_d = s4_x_q * $signed(trim_i.p5);
  assign s5_xp2_d = s4_x_q * $signed(trim_i.p2);

  // S6
  logic signed [63:0] s6_xxp6_d, s6_xxp6_q, s6_xxp3_d, s6_xxp3_q;
  logic signed [39:0] s6_xp5_q, s6_xp2_q;

  assign s6_xxp6_d = s5_xx_q * $signed(trim_i.p6);
  assign s6_xxp3_d = s5_xx_q * $signed(trim_i.p3);

  // S7: var2 and biased var1
  logic signed [63:0] s7_v2_d, s7_v2_q, s7_v1b_d, s7_v1b_q;

  assign s7_v2_d  = s6_xxp6_q + (64'(s6_xp5_q) <<< 17) + (64'($signed(trim_i.p4)) <<< 35);
  assign s7_v1b_d = (s6_xxp3_q >>> 8) + (64'(s6_xp2_q) <<< 12) + V1_BIAS;

  // S8: numerator base, var1 times P1 in two halves
  logic [20:0] s8_pp;
  logic [63:0] s8_num_d, s8_num_q;
  logic [47:0] s8_lo_d, s8_lo_q, s8_hi_full;
  logic [31:0] s8_hi_q;

  assign s8_pp      = PRESS_FULL - 21'(rp_q[6]);
  assign s8_num_d   = (64'(s8_pp) << 31) - s7_v2_q;
  assign s8_lo_d    = s7_v1b_q[31:0] * trim_i.p1;
  assign s8_hi_full = s7_v1b_q[63:32] * trim_i.p1;

  // S9: divisor, numerator scaling in two halves
  logic [63:0]        s9_v1p;
  logic signed [63:0] s9_v1w;
  logic signed [30:0] s9_v1_d, s9_v1_q;
  logic [43:0]        s9_nlo_d, s9_nlo_q, s9_nhi_full;
  logic [31:0]        s9_nhi_q;

  assign s9_v1p      = 64'(s8_lo_q) + {s8_hi_q, 32'b0};
  assign s9_v1w      = $signed(s9_v1p) >>> 33;
  assign s9_v1_d     = s9_v1w[30:0];
  assign s9_nlo_d    = s8_num_q[31:0] * DIV_SCALE;
  assign s9_nhi_full = s8_num_q[63:32] * DIV_SCALE;

  // S10
  logic [63:0]        s10_n_d, s10_n_q;
  logic signed [30:0] s10_v1_q;

  assign s10_n_d = 64'(s9_nlo_q) + {s9_nhi_q, 32'b0};

  // S11: sign and magnitude for the divider
  div_req_t    s11_d, s11_q;
  logic [30:0] s11_ud;

  assign s11_ud = s10_v1_q[30] ? (31'd0 - s10_v1_q) : s10_v1_q;

  always_comb begin
    s11_d.side.temp = tmp_q[6];
    s11_d.side.dz   = (s10_v1_q == '0);
    s11_d.side.neg  = s10_n_q[63] ^ s10_v1_q[30];
    s11_d.side.ud   = s11_ud;
    s11_d.un        = s10_n_q[63] ? (64'd0 - s10_n_q) : s10_n_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pa_q   <= s1_pa_d;
      s1_bb_q   <= s1_bb_d;
      s2_v1t_q  <= s2_v1t_w[20:0];
      s2_m_q    <= s2_m_d;
      s3_tf_q   <= s3_tf_d;
      s4_x_q    <= s4_x_d;
      s5_xx_q   <= s5_xx_d;
      s5_xp5_q  <= s5_xp5_d;
      s5_xp2_q  <= s5_xp2_d;
      s6_xxp6_q <= s6_xxp6_d;
      s6_xxp3_q <= s6_xxp3_d;
      s6_xp5_q  <= s5_xp5_q;
      s6_xp2_q  <= s5_xp2_q;
      s7_v2_q   <= s7_v2_d;
      s7_v1b_q  <= s7_v1b_d;
      s8_num_q  <= s8_num_d;
      s8_lo_q   <= s8_lo_d;
      s8_hi_q   <= s8_hi_full[31:0];
      s9_v1_q   <= s9_v1_d;
      s9_nlo_q  <= s9_nlo_d;
      s9_nhi_q  <= s9_nhi_full[31:0];
      s10_n_q   <= s10_n_d;
      s10_v1_q  <= s9_v1_q;
      s11_q     <= s11_d;
      rp_q[0]   <= in_req_i.raw_press;
      tmp_q[0]  <= s4_temp_d;
      for (int i = 1; i < 7; i++) begin
        rp_q[i]  <= rp_q[i-1];
        tmp_q[i] <= tmp_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_req_o   = s11_q;

endmodule

`default_nettype wire

/* rtl/bsc_div.sv */
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  bsc_pkg::div_req_t  in_req_i,
  output logic               out_valid_o,
  output bsc_pkg::div_res_t  out_res_o
);
  import bsc_pkg::*;

  logic [DIV_STG-1:0] vld_q;
  logic [30:0]        rem_q  [DIV_STG];
  logic [63:0]        num_q  [DIV_STG];
  div_side_t          side_q [DIV_STG];

  for (genvar k = 0; k < DIV_STG; k++) begin : g_stg
    logic [30:0] rem_in, rem_d;
    logic [63:0] num_in;
    div_side_t   side_in;
    logic [31:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = in_req_i.un;
      assign side_in = in_req_i.side;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign num_in  = num_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, num_in[63]};
    assign ge    = trial >= {1'b0, side_in.ud};
    assign rem_d = ge ? 31'(trial - {1'b0, side_in.ud}) : trial[30:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        num_q[k]  <= {num_in[62:0], ge};  // quotient bits fill from the right
        side_q[k] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_STG-2:0], in_valid_i};
    end
  end

  assign out_valid_o    = vld_q[DIV_STG-1];
  assign out_res_o.side = side_q[DIV_STG-1];
  assign out_res_o.quo  = num_q[DIV_STG-1];

`include "baro_sensor_compensation_assert.svh"

  `BSC_ASSERT_NXT(a_div_tail_moves, clk_i, rst_ni, en_i && vld_q[DIV_STG-2], vld_q[DIV_STG-1], "divider lost a request at its last stage")

endmodule

`default_nettype wire

/* rtl/bsc_back.sv */
// ----------------------------------------------------------------------------
// bsc_back
// Pressure correction after the division, and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  bsc_pkg::div_res_t  in_res_i,
  input  bsc_pkg::trim_t     trim_i,
  output logic               out_valid_o,
  output bsc_pkg::res_out_t  out_res_o
);
  import bsc_pkg::*;

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0]    vld_q;
  logic signed [31:0] tmp_q [6];
  logic               dz_q  [6];

  // B1: signed quotient
  logic signed [63:0] b1_p_d, b1_p_q;
  assign b1_p_d = in_res_i.side.neg ? (64'sd0 - in_res_i.quo) : in_res_i.quo;

  // B2: P9*ps and P8*p in halves
  logic signed [63:0] b2_ps_d, b2_ps_q, b2_p_q;
  logic signed [48:0] b2_lo1_d, b2_lo1_q, b2_lo2_d, b2_lo2_q;
  logic signed [47:0] b2_hi1_full, b2_hi2_full;
  logic [31:0]        b2_hi1_q, b2_hi2_q;

  assign b2_ps_d     = b1_p_q >>> 13;
  assign b2_lo1_d    = $signed({1'b0, b2_ps_d[31:0]}) * $signed(trim_i.p9);
  assign b2_hi1_full = $signed(b2_ps_d[63:32]) * $signed(trim_i.p9);
  assign b2_lo2_d    = $signed({1'b0, b1_p_q[31:0]}) * $signed(trim_i.p8);
  assign b2_hi2_full = $signed(b1_p_q[63:32]) * $signed(trim_i.p8);

  // B3
  logic signed [63:0] b3_lo1w, b3_lo2w, b3_m1_d, b3_m1_q, b3_w2s, b3_w2_d;
  logic signed [63:0] b3_p_q, b3_ps_q, b3_w2_q;

  assign b3_lo1w = 64'(b2_lo1_q);
  assign b3_lo2w = 64'(b2_lo2_q);
  assign b3_m1_d = b3_lo1w + {b2_hi1_q, 32'b0};
  assign b3_w2s  = b3_lo2w + {b2_hi2_q, 32'b0};
  assign b3_w2_d = b3_w2s >>> 19;

  // B4: low 64 bits of m1*ps from three partial products
  logic [63:0] b4_pa_d, b4_pa_q, b4_pb_full, b4_pc_full;
  logic [31:0] b4_pb_q, b4_pc_q;
  logic signed [63:0] b4_p_q, b4_w2_q;

  assign b4_pa_d    = b3_m1_q[31:0] * b3_ps_q[31:0];
  assign b4_pb_full = b3_m1_q[31:0] * b3_ps_q[63:32];
  assign b4_pc_full = b3_m1_q[63:32] * b3_ps_q[31:0];

  // B5
  logic [31:0]        b5_mid;
  logic signed [63:0] b5_m2, b5_w1_d, b5_w1_q, b5_p_q, b5_w2_q;

  assign b5_mid  = b4_pb_q + b4_pc_q;
  assign b5_m2   = b4_pa_q + {b5_mid, 32'b0};
  assign b5_w1_d = b5_m2 >>> 25;

  // B6
  logic signed [63:0] b6_s_d, b6_s_q;
  assign b6_s_d = b5_p_q + b5_w1_q + b5_w2_q;

  // B7: scale, P7 offset, clamp
  logic signed [63:0] b7_f;
  res_out_t           b7_d, b7_q;

  assign b7_f = (b6_s_q >>> 8) + (64'($signed(trim_i.p7)) <<< 4);

  always_comb begin
    b7_d.temp_centi    = tmp_q[5];
    b7_d.press_invalid = dz_q[5];
    if (dz_q[5] || b7_f[63]) begin
      b7_d.press_q24_8 = '0;
    end else if (b7_f[63:32] != '0) begin
      b7_d.press_q24_8 = '1;
    end else begin
      b7_d.press_q24_8 = b7_f[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_p_q   <= b1_p_d;
      b2_ps_q  <= b2_ps_d;
      b2_p_q   <= b1_p_q;
      b2_lo1_q <= b2_lo1_d;
      b2_lo2_q <= b2_lo2_d;
      b2_hi1_q <= b2_hi1_full[31:0];
      b2_hi2_q <= b2_hi2_full[31:0];
      b3_m1_q  <= b3_m1_d;
      b3_w2_q  <= b3_w2_d;
      b3_p_q   <= b2_p_q;
      b3_ps_q  <= b2_ps_q;
      b4_pa_q  <= b4_pa_d;
      b4_pb_q  <= b4_pb_full[31:0];
      b4_pc_q  <= b4_pc_full[31:0];
      b4_p_q   <= b3_p_q;
      b4_w2_q  <= b3_w2_q;
      b5_w1_q  <= b5_w1_d;
      b5_p_q   <= b4_p_q;
      b5_w2_q  <= b4_w2_q;
      b6_s_q   <= b6_s_d;
      b7_q     <= b7_d;
      tmp_q[0] <= in_res_i.side.temp;
      dz_q[0]  <= in_res_i.side.dz;
      for (int i = 1; i < 6; i++) begin
        tmp_q[i] <= tmp_q[i-1];
        dz_q[i]  <= dz_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_res_o   = b7_q;

`include "baro_sensor_compensation_assert.svh"

  `BSC_ASSERT_NXT(a_back_tail_moves, clk_i, rst_ni, en_i && vld_q[NSTG-2], vld_q[NSTG-1], "back end lost a request before the output")

endmodule

`default_nettype wire
